// File: hw/rtl/txcw_pkg.sv
// Shared types and constants for the text console character writer.
// Holds field widths, operation codes, command classes and back-end states.
// No dependencies.
`default_nettype none

package txcw_pkg;

  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int ENTRY_W = ATTR_W + CHAR_W;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_READ,
    CMD_READ_BLANK,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAR_W-1:0]  character;
    logic [ROW_W-1:0]   read_row;
    logic [COL_W-1:0]   read_column;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_RESULT
  } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/txcw_ram.sv
// Generic single-port RAM with registered read data.
// Parameters set word width and depth; no dependencies.
`default_nettype none

module txcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/txcw_front.sv
// Input side: accepts transactions and classifies them into back-end commands.
// Depends on txcw_pkg.
`default_nettype none

module txcw_front #(
  parameter int COLUMNS = txcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = txcw_pkg::DEF_ROWS
) (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [txcw_pkg::OP_W-1:0]     in_operation,
  input  wire logic [txcw_pkg::CHAR_W-1:0]   in_character,
  input  wire logic [txcw_pkg::ROW_W-1:0]    in_read_row,
  input  wire logic [txcw_pkg::COL_W-1:0]    in_read_column,
  input  wire txcw_pkg::back_status_t        status,
  input  wire logic                          queue_full,
  output logic                               push,
  output txcw_pkg::cmd_t                     cmd
);

  import txcw_pkg::*;

  localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W+1)'(ROWS);
  localparam logic [COL_W:0] COL_LIMIT = (COL_W+1)'(COLUMNS);

  logic in_range;

  assign in_range = ({1'b0, in_read_row} < ROW_LIMIT) &&
                    ({1'b0, in_read_column} < COL_LIMIT);

  assign in_stall = queue_full || status.init_busy;
  assign push     = in_valid && !in_stall;

  always_comb begin
    cmd.character   = in_character;
    cmd.read_row    = in_read_row;
    cmd.read_column = in_read_column;
    case (in_operation)
      OP_PUT: begin
        cmd.kind = (in_character == NEWLINE_CHAR) ? CMD_NEWLINE : CMD_PUT;
      end
      OP_READ: begin
        cmd.kind = in_range ? CMD_READ : CMD_READ_BLANK;
      end
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/txcw_fifo.sv
// Short command queue between the front and back parts, show-ahead output.
// Depends on txcw_pkg.
`default_nettype none

module txcw_fifo #(
  parameter int DEPTH = txcw_pkg::FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire txcw_pkg::cmd_t  push_data,
  input  wire logic            pop,
  output txcw_pkg::cmd_t       head,
  output logic                 empty,
  output logic                 full
);

  import txcw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? next_ptr(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? next_ptr(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/txcw_back.sv
// Back part: cursor, ring of screen rows, cell store sweeps and result register.
// Depends on txcw_pkg; drives an external txcw_ram instance.
`default_nettype none

module txcw_back #(
  parameter int COLUMNS = txcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = txcw_pkg::DEF_ROWS,
  parameter int ADDR_W  = $clog2(ROWS * COLUMNS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_write_enable,
  input  wire logic [txcw_pkg::ATTR_W-1:0]   cfg_write_data,
  input  wire logic                          cmd_valid,
  input  wire txcw_pkg::cmd_t                cmd,
  output logic                               cmd_pop,
  output txcw_pkg::back_status_t             status,
  output logic                               ram_we,
  output logic      [ADDR_W-1:0]             ram_addr,
  output logic      [txcw_pkg::ENTRY_W-1:0]  ram_wdata,
  input  wire logic [txcw_pkg::ENTRY_W-1:0]  ram_rdata,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [txcw_pkg::ENTRY_W-1:0]  out_cell_entry,
  output logic      [txcw_pkg::ROW_W-1:0]    out_cursor_row,
  output logic      [txcw_pkg::COL_W-1:0]    out_cursor_column,
  output logic                               out_scrolled
);

  import txcw_pkg::*;

  localparam int                CELLS     = ROWS * COLUMNS;
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);

  back_state_t        state_r, state_nxt;
  logic [ATTR_W-1:0]  attr_r, attr_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   top_r, top_nxt;
  logic [ENTRY_W-1:0] blank_r, blank_nxt;
  logic [ADDR_W-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic [ADDR_W-1:0]  sweep_end_r, sweep_end_nxt;
  logic               sweep_rsp_r, sweep_rsp_nxt;
  logic [ENTRY_W-1:0] res_entry_r, res_entry_nxt;
  logic               res_scrolled_r, res_scrolled_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ENTRY_W-1:0] out_entry_r, out_entry_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [COL_W-1:0]   out_col_r, out_col_nxt;
  logic               out_scrolled_r, out_scrolled_nxt;

  logic [ADDR_W-1:0]  cur_addr, rd_addr, top_base;
  logic [ENTRY_W-1:0] blank_now, put_entry;
  logic               advance_row, scroll, sweep_done, out_free;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] lrow,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] prow;
    sum = {1'b0, top} + {1'b0, lrow};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    prow = sum[ROW_W-1:0];
    return ADDR_W'(prow) * COLS_A + ADDR_W'(col);
  endfunction

  assign cur_addr    = cell_addr(top_r, cur_row_r, cur_col_r);
  assign rd_addr     = cell_addr(top_r, cmd.read_row, cmd.read_column);
  assign top_base    = ADDR_W'(top_r) * COLS_A;
  assign blank_now   = {attr_r, {CHAR_W{1'b0}}};
  assign put_entry   = {attr_r, cmd.character};
  assign advance_row = (cmd.kind == CMD_NEWLINE) || (cur_col_r == COL_LAST);
  assign scroll      = advance_row && (cur_row_r == ROW_LAST);
  assign sweep_done  = (sweep_addr_r == sweep_end_r);
  assign out_free    = !out_valid_r || !out_stall;

  assign status.init_busy  = (state_r == ST_SWEEP) && !sweep_rsp_r;
  assign out_valid         = out_valid_r;
  assign out_cell_entry    = out_entry_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_column = out_col_r;
  assign out_scrolled      = out_scrolled_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_PUT, CMD_NEWLINE: state_nxt = scroll ? ST_SWEEP : ST_RESULT;
            CMD_READ:             state_nxt = ST_READ;
            CMD_CLEAR:            state_nxt = ST_SWEEP;
            default:              state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_RESULT;
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = sweep_rsp_r ? ST_RESULT : ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    attr_nxt         = cfg_write_enable ? cfg_write_data : attr_r;
    cur_row_nxt      = cur_row_r;
    cur_col_nxt      = cur_col_r;
    top_nxt          = top_r;
    blank_nxt        = blank_r;
    sweep_addr_nxt   = sweep_addr_r;
    sweep_end_nxt    = sweep_end_r;
    sweep_rsp_nxt    = sweep_rsp_r;
    res_entry_nxt    = res_entry_r;
    res_scrolled_nxt = res_scrolled_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_entry_nxt    = out_entry_r;
    out_row_nxt      = out_row_r;
    out_col_nxt      = out_col_r;
    out_scrolled_nxt = out_scrolled_r;
    cmd_pop          = 1'b0;
    ram_we           = 1'b0;
    ram_addr         = '0;
    ram_wdata        = blank_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop          = 1'b1;
          res_entry_nxt    = '0;
          res_scrolled_nxt = 1'b0;
          case (cmd.kind)
            CMD_PUT, CMD_NEWLINE: begin
              if (cmd.kind == CMD_PUT) begin
                ram_we        = 1'b1;
                ram_addr      = cur_addr;
                ram_wdata     = put_entry;
                res_entry_nxt = put_entry;
              end
              if (advance_row) begin
                cur_col_nxt = '0;
                if (scroll) begin
                  top_nxt          = (top_r == ROW_LAST) ? '0 : top_r + 1'b1;
                  blank_nxt        = blank_now;
                  sweep_addr_nxt   = top_base;
                  sweep_end_nxt    = top_base + COLS_A - 1'b1;
                  sweep_rsp_nxt    = 1'b1;
                  res_scrolled_nxt = 1'b1;
                end else begin
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
            end
            CMD_READ: begin
              ram_addr = rd_addr;
            end
            CMD_READ_BLANK: begin
              res_entry_nxt = blank_now;
            end
            CMD_CLEAR: begin
              cur_row_nxt    = '0;
              cur_col_nxt    = '0;
              top_nxt        = '0;
              blank_nxt      = blank_now;
              sweep_addr_nxt = '0;
              sweep_end_nxt  = CELL_LAST;
              sweep_rsp_nxt  = 1'b1;
            end
            default: begin
              res_entry_nxt = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        res_entry_nxt = ram_rdata;
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_addr  = sweep_addr_r;
        ram_wdata = blank_r;
        if (!sweep_done) begin
          sweep_addr_nxt = sweep_addr_r + 1'b1;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_entry_nxt    = res_entry_r;
          out_row_nxt      = cur_row_r;
          out_col_nxt      = cur_col_r;
          out_scrolled_nxt = res_scrolled_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_SWEEP;
      attr_r         <= ATTR_RESET;
      cur_row_r      <= '0;
      cur_col_r      <= '0;
      top_r          <= '0;
      blank_r        <= {ATTR_RESET, {CHAR_W{1'b0}}};
      sweep_addr_r   <= '0;
      sweep_end_r    <= CELL_LAST;
      sweep_rsp_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      attr_r         <= attr_nxt;
      cur_row_r      <= cur_row_nxt;
      cur_col_r      <= cur_col_nxt;
      top_r          <= top_nxt;
      blank_r        <= blank_nxt;
      sweep_addr_r   <= sweep_addr_nxt;
      sweep_end_r    <= sweep_end_nxt;
      sweep_rsp_r    <= sweep_rsp_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_entry_r    <= res_entry_nxt;
    res_scrolled_r <= res_scrolled_nxt;
    out_entry_r    <= out_entry_nxt;
    out_row_r      <= out_row_nxt;
    out_col_r      <= out_col_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

`ifndef ASSERT_OFF
  a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r <= ROW_LAST) && (cur_col_r <= COL_LAST) && (top_r <= ROW_LAST))
    else $error("cursor or top row outside the screen");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (sweep_addr_r <= sweep_end_r) && (sweep_end_r <= CELL_LAST))
    else $error("blanking sweep outside its range");

  a_read_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && cmd_valid && (cmd.kind == CMD_READ) |=> (state_r == ST_READ))
    else $error("read did not wait for store data");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_scrolled_r |-> (out_row_r == ROW_LAST) && (out_col_r == '0))
    else $error("scrolled transaction with cursor off the last row start");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/text_console_character_writer.sv
// Top level of the text console character writer.
// Depends on txcw_pkg, txcw_front, txcw_fifo, txcw_back and txcw_ram.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    operation, character, read_row, read_column
//   out_     output     out_valid / out_stall  cell_entry, cursor_row, cursor_column, scrolled
//   cfg_     input      cfg_write_enable       cfg_write_data (text attribute)
//
// Put and newline pass through the back-end states ST_IDLE and ST_RESULT; a read also passes
// through ST_READ to wait for the registered store read data. A scroll blanks one row of COLUMNS
// cells and a clear all ROWS*COLUMNS cells, one cell a cycle through the single store port.
// After reset all ROWS*COLUMNS cells (2000 by default) of the store are blanked with in_stall high.
// A two-entry command queue keeps accepting until full while a result waits on out_stall.
`default_nettype none

module text_console_character_writer #(
  parameter int COLUMNS = txcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = txcw_pkg::DEF_ROWS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_write_enable,
  input  wire logic [txcw_pkg::ATTR_W-1:0]   cfg_write_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [txcw_pkg::OP_W-1:0]     in_operation,
  input  wire logic [txcw_pkg::CHAR_W-1:0]   in_character,
  input  wire logic [txcw_pkg::ROW_W-1:0]    in_read_row,
  input  wire logic [txcw_pkg::COL_W-1:0]    in_read_column,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [txcw_pkg::ENTRY_W-1:0]  out_cell_entry,
  output logic      [txcw_pkg::ROW_W-1:0]    out_cursor_row,
  output logic      [txcw_pkg::COL_W-1:0]    out_cursor_column,
  output logic                               out_scrolled
);

  import txcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  back_status_t       status;
  cmd_t               front_cmd, queue_head;
  logic               push, queue_full, queue_empty, cmd_pop;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  txcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_character   (in_character),
    .in_read_row    (in_read_row),
    .in_read_column (in_read_column),
    .status         (status),
    .queue_full     (queue_full),
    .push           (push),
    .cmd            (front_cmd)
  );

  txcw_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_cmd),
    .pop       (cmd_pop),
    .head      (queue_head),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  txcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_enable  (cfg_write_enable),
    .cfg_write_data    (cfg_write_data),
    .cmd_valid         (!queue_empty),
    .cmd               (queue_head),
    .cmd_pop           (cmd_pop),
    .status            (status),
    .ram_we            (ram_we),
    .ram_addr          (ram_addr),
    .ram_wdata         (ram_wdata),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_entry    (out_cell_entry),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column),
    .out_scrolled      (out_scrolled)
  );

  txcw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_text_console_character_writer.sv
// Self-checking testbench for text_console_character_writer: a screen scoreboard predicts every
// put, read, clear and unused operation, including scrolls, against the block's results.
// Depends on txcw_pkg and the RTL of text_console_character_writer.
`timescale 1ns / 100ps

import txcw_pkg::*;

localparam int SCREEN_COLUMNS = txcw_pkg::DEF_COLUMNS;
localparam int SCREEN_ROWS    = txcw_pkg::DEF_ROWS;
localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

typedef struct packed {
  logic [ENTRY_W-1:0] entry;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   column;
  logic               scrolled;
} console_result_t;

class screen_scoreboard;
  logic [ENTRY_W-1:0] screen_cells [0:SCREEN_CELLS-1];
  int unsigned        top_row;
  int unsigned        cursor_row;
  int unsigned        cursor_column;
  logic [ATTR_W-1:0]  text_attribute;
  console_result_t    expected_results [$];
  int                 mismatches;

  function new();
    text_attribute = ATTR_RESET;
    mismatches = 0;
    clear_screen();
  endfunction

  function logic [ENTRY_W-1:0] blank_entry();
    return {text_attribute, {CHAR_W{1'b0}}};
  endfunction

  function void clear_screen();
    for (int i = 0; i < SCREEN_CELLS; i++) screen_cells[i] = blank_entry();
    top_row = 0;
    cursor_row = 0;
    cursor_column = 0;
  endfunction

  function int unsigned cell_index(int unsigned row, int unsigned column);
    return ((top_row + row) % SCREEN_ROWS) * SCREEN_COLUMNS + column;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void note_command(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                             logic [ROW_W-1:0] rrow, logic [COL_W-1:0] rcol);
    console_result_t r;
    r = '0;
    if (op == OP_PUT) begin
      if (ch == NEWLINE_CHAR) begin
        cursor_column = 0;
        cursor_row++;
      end else begin
        r.entry = {text_attribute, ch};
        screen_cells[cell_index(cursor_row, cursor_column)] = r.entry;
        cursor_column++;
        if (cursor_column >= SCREEN_COLUMNS) begin
          cursor_column = 0;
          cursor_row++;
        end
      end
      if (cursor_row >= SCREEN_ROWS) begin
        // blank the physical top row, then make it the bottom
        for (int c = 0; c < SCREEN_COLUMNS; c++)
          screen_cells[top_row * SCREEN_COLUMNS + c] = blank_entry();
        top_row = (top_row + 1) % SCREEN_ROWS;
        cursor_row = SCREEN_ROWS - 1;
        r.scrolled = 1'b1;
      end
    end else if (op == OP_READ) begin
      if (rrow < SCREEN_ROWS && rcol < SCREEN_COLUMNS) begin
        r.entry = screen_cells[cell_index(rrow, rcol)];
      end else begin
        r.entry = blank_entry();
      end
    end else if (op == OP_CLEAR) begin
      clear_screen();
    end
    r.row = ROW_W'(cursor_row);
    r.column = COL_W'(cursor_column);
    expected_results.push_back(r);
  endfunction

  function void check_result(console_result_t got);
    console_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: entry %h row %0d column %0d scrolled %0b",
                 got.entry, got.row, got.column, got.scrolled);
      return;
    end
    want = expected_results.pop_front();
    if (want.entry !== got.entry || want.row !== got.row || want.column !== got.column ||
        want.scrolled !== got.scrolled) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %h/%0d/%0d/%0b, got %h/%0d/%0d/%0b",
                 want.entry, want.row, want.column, want.scrolled,
                 got.entry, got.row, got.column, got.scrolled);
    end
  endfunction
endclass

module tb_text_console_character_writer;

  localparam int SETTLE_CYCLES  = SCREEN_CELLS + 100;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int ITEMS_PER_PHASE = 310;

  logic               clk;
  logic               rst_n;
  logic               cfg_write_enable;
  logic [ATTR_W-1:0]  cfg_write_data;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    in_operation;
  logic [CHAR_W-1:0]  in_character;
  logic [ROW_W-1:0]   in_read_row;
  logic [COL_W-1:0]   in_read_column;
  logic               out_valid;
  logic               out_stall;
  logic [ENTRY_W-1:0] out_cell_entry;
  logic [ROW_W-1:0]   out_cursor_row;
  logic [COL_W-1:0]   out_cursor_column;
  logic               out_scrolled;

  screen_scoreboard sb;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               line_left = 0;
  int               cycle_count = 0;

  text_console_character_writer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_enable  (cfg_write_enable),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_character      (in_character),
    .in_read_row       (in_read_row),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_entry    (out_cell_entry),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column),
    .out_scrolled      (out_scrolled)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result({out_cell_entry, out_cursor_row, out_cursor_column, out_scrolled});
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                           logic [ROW_W-1:0] rrow, logic [COL_W-1:0] rcol);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_character   <= ch;
    in_read_row    <= rrow;
    in_read_column <= rcol;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_command(op, ch, rrow, rcol);
  endtask

  task automatic hold_until_drained(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] attribute);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= attribute;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    sb.text_attribute = attribute;
  endtask

  task automatic send_random_item();
    int                pick;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rrow;
    logic [COL_W-1:0]  rcol;
    pick = $urandom_range(0, 999);
    ch   = CHAR_W'($urandom_range(0, 255));
    rrow = ROW_W'($urandom_range(0, 31));
    rcol = COL_W'($urandom_range(0, 127));
    if (pick < 3) begin
      op = OP_CLEAR;
    end else if (pick < 20) begin
      op = OP_UNUSED;
    end else if (pick < 250) begin
      op = OP_READ;
      if ($urandom_range(0, 3) != 0) begin
        rrow = $urandom_range(0, 1) ? ROW_W'(sb.cursor_row) :
                                      ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
        rcol = COL_W'($urandom_range(0, SCREEN_COLUMNS - 1));
      end
    end else begin
      op = OP_PUT;
      if (line_left == 0) begin
        ch = NEWLINE_CHAR;
        pick = $urandom_range(0, 99);
        if (pick < 50) line_left = 0;
        else if (pick < 75) line_left = $urandom_range(1, 8);
        else if (pick < 95) line_left = $urandom_range(9, SCREEN_COLUMNS - 1);
        else line_left = $urandom_range(SCREEN_COLUMNS, 200);
      end else begin
        line_left--;
      end
    end
    send_item(op, ch, rrow, rcol);
    if ($urandom_range(0, 299) == 0) hold_until_drained(0);
  endtask

  initial begin
    logic [ATTR_W-1:0] attribute;
    sb = new();
    rst_n            <= 1'b0;
    cfg_write_enable <= 1'b0;
    cfg_write_data   <= '0;
    in_valid         <= 1'b0;
    in_operation     <= OP_PUT;
    in_character     <= '0;
    in_read_row      <= '0;
    in_read_column   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);

    send_item(OP_READ, 8'h5A, 5'd0, 7'd0);
    send_item(OP_READ, 8'hA5, ROW_W'(SCREEN_ROWS - 1), COL_W'(SCREEN_COLUMNS - 1));
    send_item(OP_READ, 8'h00, ROW_W'(SCREEN_ROWS), 7'd0);
    send_item(OP_READ, 8'hFF, 5'd0, COL_W'(SCREEN_COLUMNS));
    send_item(OP_READ, 8'h0A, 5'd31, 7'd127);
    send_item(OP_PUT, 8'h00, 5'd31, 7'd127);
    send_item(OP_PUT, 8'hFF, 5'd0, 7'd0);
    send_item(OP_PUT, 8'h41, 5'd21, 7'd85);
    send_item(OP_PUT, NEWLINE_CHAR, 5'd10, 7'd42);
    send_item(OP_PUT, 8'h0B, 5'd0, 7'd0);
    send_item(OP_PUT, 8'h09, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd0, 7'd1);
    send_item(OP_READ, 8'h00, 5'd0, 7'd2);
    send_item(OP_READ, 8'h00, 5'd1, 7'd0);
    send_item(OP_UNUSED, 8'hFF, 5'd31, 7'd127);
    send_item(OP_UNUSED, 8'h00, 5'd0, 7'd0);
    send_item(OP_CLEAR, 8'hFF, 5'd31, 7'd127);
    send_item(OP_READ, 8'h00, 5'd1, 7'd0);
    send_item(OP_READ, 8'h00, 5'd0, 7'd0);

    for (int phase = 0; phase < 6; phase++) begin
      hold_until_drained(SETTLE_CYCLES);
      case (phase)
        0: attribute = 8'h00;
        1: attribute = 8'hFF;
        3: attribute = 8'h1F;
        default: attribute = ATTR_W'($urandom_range(0, 255));
      endcase
      write_attribute(attribute);
      if (phase < 2) begin
        send_idle_pct = 15;
        stall_pct     = 48;
      end else if (phase < 4) begin
        send_idle_pct = 48;
        stall_pct     = 15;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    hold_until_drained(SETTLE_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
